@@ src/smartcard_char_transceiver_top_defines.svh @@
// ----------------------------------------------------------------------------
// Smart-card character transceiver assertion macros
// Shared macros for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SMARTCARD_CHAR_TRANSCEIVER_TOP_DEFINES_SVH
`define SMARTCARD_CHAR_TRANSCEIVER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// Smart-card character transceiver package
// Payload types, phase encoding, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sct_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RX   = 2'd1,
    PH_TX   = 2'd2
  } phase_t;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_ETU_CYCLES         = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_SAMPLE_DELAY = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GUARD_ETUS         = 2'd2;

  localparam logic [15:0] ETU_CYCLES_RST         = 16'd372;
  localparam logic [15:0] FIRST_SAMPLE_DELAY_RST = 16'd558;
  localparam logic [3:0]  GUARD_ETUS_RST         = 4'd3;

  // Character frame: start bit, eight data bits, parity bit.
  localparam logic [5:0] FRAME_SLOTS = 6'd10;
  localparam logic [4:0] RX_PARITY_SLOT = 5'd8;

  typedef struct packed {
    logic       line_in;
    logic       tx_start;
    logic [7:0] tx_byte;
  } in_t;

  typedef struct packed {
    logic       drive_low;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_parity_error;
    logic       tx_accepted;
    logic       tx_done;
    logic       busy_res;
  } out_t;

endpackage

@@ src/sct_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input stage
// Holds one accepted input beat until the core consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sct_in_stage
  import sct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_payload,
  input  logic advance,
  output logic s1_valid,
  output in_t  s1_data
);

  logic s1_valid_r;
  logic s1_valid_nxt;
  in_t  s1_data_r;

  assign in_ready = !s1_valid_r || advance;
  assign s1_valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_payload;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

@@ src/sct_core.sv @@
// ----------------------------------------------------------------------------
// Transceiver core
// Character state, configuration registers and the per-tick update logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sct_core
  import sct_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                step,
  input  in_t                 s1_data,
  output out_t                result
);

  logic [15:0] etu_r;
  logic [15:0] fsd_r;
  logic [3:0]  guard_r;

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [4:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  rx_shift_r, rx_shift_nxt;
  logic [9:0]  tx_frame_r, tx_frame_nxt;
  logic [4:0]  history_r, history_nxt;
  logic        last_line_r;
  logic        line_drive_r, line_drive_nxt;

  logic [15:0] tick_inc;
  logic [15:0] etu_eff;
  logic [15:0] rx_target;
  logic        rx_hit;
  logic        tx_hit;
  logic        bit_val;
  logic        falling;
  logic [4:0]  bit_inc;
  logic        tx_end;
  logic [9:0]  new_frame;

  function automatic logic maj5(input logic [4:0] h);
    logic [2:0] n;
    n = 3'(h[0]) + 3'(h[1]) + 3'(h[2]) + 3'(h[3]) + 3'(h[4]);
    return n >= 3'd3;
  endfunction

  // Level driven in a given ETU slot: released during guard time and past the frame.
  function automatic logic slot_drive(input logic [4:0] bidx, input logic [3:0] guard,
                                      input logic [9:0] frame);
    logic [5:0] pos;
    pos = {1'b0, bidx} - {2'b00, guard};
    if ({1'b0, bidx} < {2'b00, guard}) begin
      return 1'b0;
    end
    if (pos >= FRAME_SLOTS) begin
      return 1'b0;
    end
    return !frame[pos[3:0]];
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etu_r   <= ETU_CYCLES_RST;
      fsd_r   <= FIRST_SAMPLE_DELAY_RST;
      guard_r <= GUARD_ETUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ETU_CYCLES:         etu_r   <= cfg_data;
        CFG_FIRST_SAMPLE_DELAY: fsd_r   <= cfg_data;
        CFG_GUARD_ETUS:         guard_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign tick_inc  = (tick_count_r == 16'hFFFF) ? tick_count_r : tick_count_r + 16'd1;
  assign etu_eff   = (etu_r == 16'd0) ? 16'd1 : etu_r;
  assign rx_target = (bit_index_r != 5'd0) ? etu_eff :
                     ((fsd_r == 16'd0) ? 16'd1 : fsd_r);
  assign rx_hit    = tick_inc >= rx_target;
  assign tx_hit    = tick_inc >= etu_eff;
  assign history_nxt = {history_r[3:0], s1_data.line_in};
  assign bit_val   = maj5(history_nxt);
  assign falling   = last_line_r && !s1_data.line_in;
  assign bit_inc   = bit_index_r + 5'd1;
  assign tx_end    = {1'b0, bit_inc} >= ({2'b00, guard_r} + FRAME_SLOTS);
  assign new_frame = {^s1_data.tx_byte, s1_data.tx_byte, 1'b0};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_RX: begin
        if (rx_hit && (bit_index_r >= RX_PARITY_SLOT)) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_TX: begin
        if (tx_hit && tx_end) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_IDLE: begin
        if (s1_data.tx_start) begin
          phase_nxt = PH_TX;
        end else if (falling) begin
          phase_nxt = PH_RX;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    tick_count_nxt = tick_count_r;
    bit_index_nxt  = bit_index_r;
    rx_shift_nxt   = rx_shift_r;
    tx_frame_nxt   = tx_frame_r;
    line_drive_nxt = line_drive_r;
    result         = '0;
    case (phase_r)
      PH_RX: begin
        tick_count_nxt = tick_inc;
        if (rx_hit) begin
          tick_count_nxt = 16'd0;
          if (bit_index_r < RX_PARITY_SLOT) begin
            rx_shift_nxt  = rx_shift_r | (8'(bit_val) << bit_index_r[2:0]);
            bit_index_nxt = bit_inc;
          end else begin
            result.rx_valid        = 1'b1;
            result.rx_data         = rx_shift_r;
            result.rx_parity_error = bit_val ^ (^rx_shift_r);
            bit_index_nxt          = 5'd0;
          end
        end
      end
      PH_TX: begin
        tick_count_nxt = tick_inc;
        if (tx_hit) begin
          tick_count_nxt = 16'd0;
          if (tx_end) begin
            line_drive_nxt = 1'b0;
            result.tx_done = 1'b1;
            bit_index_nxt  = 5'd0;
          end else begin
            bit_index_nxt  = bit_inc;
            line_drive_nxt = slot_drive(bit_inc, guard_r, tx_frame_r);
          end
        end
      end
      PH_IDLE: begin
        if (s1_data.tx_start) begin
          result.tx_accepted = 1'b1;
          tick_count_nxt     = 16'd0;
          bit_index_nxt      = 5'd0;
          tx_frame_nxt       = new_frame;
          line_drive_nxt     = slot_drive(5'd0, guard_r, new_frame);
        end else if (falling) begin
          tick_count_nxt = 16'd0;
          bit_index_nxt  = 5'd0;
          rx_shift_nxt   = 8'd0;
        end
      end
      default: ;
    endcase
    result.drive_low = line_drive_nxt;
    result.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= 16'd0;
      bit_index_r  <= 5'd0;
      rx_shift_r   <= 8'd0;
      tx_frame_r   <= 10'h3FF;
      history_r    <= 5'h1F;
      last_line_r  <= 1'b1;
      line_drive_r <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      bit_index_r  <= bit_index_nxt;
      rx_shift_r   <= rx_shift_nxt;
      tx_frame_r   <= tx_frame_nxt;
      history_r    <= history_nxt;
      last_line_r  <= s1_data.line_in;
      line_drive_r <= line_drive_nxt;
    end
  end

endmodule

@@ src/sct_out_stage.sv @@
// ----------------------------------------------------------------------------
// Output stage
// Result register; holds a beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sct_out_stage
  import sct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  out_t result,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_payload
);

  logic out_valid_r;
  logic out_valid_nxt;
  out_t out_data_r;

  assign space = !out_valid_r || out_ready;
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= result;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_data_r;

endmodule

@@ src/smartcard_char_transceiver_top.sv @@
// ----------------------------------------------------------------------------
// Smart-card character transceiver
// Half-duplex character receiver and transmitter for one open-drain line.
// ----------------------------------------------------------------------------
// Each input beat is one tick of the ETU timebase: the sampled line level and
// an optional transmit request with its byte. Each beat yields exactly one
// result beat: the line drive, a received character when one completes, and
// the transmit accept, done and busy flags.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// ETU length, first-sample delay and guard ETUs; it is always ready.
// An input beat passes through one input register, the tick update logic and one
// result register before its result can be taken. Throughput is one beat per
// cycle while the result register has space, bounded by the single tick update
// of the character state.
// When the receiver stalls, the result register holds its beat and the input
// register fills; in_ready then drops until out_ready returns. State only
// advances when a beat moves into the result register, so no tick is lost.
// Synchronous reset returns the line to released, the character engine to
// idle and the registers to 372, 558 and 3.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "smartcard_char_transceiver_top_defines.svh"

module smartcard_char_transceiver_top
  import sct_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_payload,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic s1_valid;
  in_t  s1_data;
  logic out_space;
  logic advance;
  out_t result;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && out_space;

  sct_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .s1_data    (s1_data)
  );

  sct_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .s1_data   (s1_data),
    .result    (result)
  );

  sct_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (advance),
    .result      (result),
    .space       (out_space),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

  `SCT_ASSERT_NEXT(a_advance_loads, advance, out_valid, "result register did not load")
  `SCT_ASSERT_NOW(a_no_overwrite, in_valid && in_ready && s1_valid, advance, "input beat overwritten")
  `SCT_ASSERT_NOW(a_rx_ends_busy, out_valid && out_payload.rx_valid, !out_payload.busy_res, "busy after character received")
  `SCT_ASSERT_NOW(a_tx_flags_apart, out_valid && out_payload.tx_done, !out_payload.tx_accepted && !out_payload.busy_res, "transmit done with accept or busy")

endmodule
